// ----- src/tlru_pkg.sv -----
package tlru_pkg;

  localparam int unsigned FIELD_W = 20;

  typedef logic [1:0] action_t;

  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_INVAL  = 2'd2;

  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   page;
    logic [FIELD_W-1:0]   frame;
  } tlru_req_t;

  typedef struct packed {
    logic                 found;
    logic [FIELD_W-1:0]   frame_out;
  } tlru_rsp_t;

  // Command broadcast to every entry cell in a cycle.
  typedef enum logic [3:0] {
    CELL_HOLD,
    CELL_MATCH_PAGE,
    CELL_MATCH_FRAME,
    CELL_MARK_FREE,
    CELL_MARK_OLDEST,
    CELL_MARK_VALID,
    CELL_PICK,
    CELL_TOUCH,
    CELL_REPLACE,
    CELL_PLACE,
    CELL_DROP,
    CELL_SHIFT_FILL,
    CELL_SHIFT_TAIL
  } cell_op_e;

endpackage

// ----- src/tlru_cell.sv -----
module tlru_cell import tlru_pkg::*; #(
  parameter int unsigned PAGE_BITS = 20,
  parameter int unsigned RANK_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_op_e             op_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [FIELD_W-1:0]   frame_i,
  input  logic [RANK_BITS-1:0] key_i,
  input  logic [RANK_BITS-1:0] new_rank_i,
  input  logic                 below_i,
  output logic                 below_o,
  input  logic                 above_i,
  output logic                 above_o,
  input  logic                 nb_valid_i,
  input  logic [PAGE_BITS-1:0] nb_page_i,
  input  logic [FIELD_W-1:0]   nb_frame_i,
  input  logic [RANK_BITS-1:0] nb_rank_i,
  output logic                 valid_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic [FIELD_W-1:0]   frame_o,
  output logic [RANK_BITS-1:0] rank_o,
  output logic [RANK_BITS-1:0] sel_rank_o,
  output logic [FIELD_W-1:0]   sel_frame_o
);

  logic                 valid_q, valid_d;
  logic [RANK_BITS-1:0] rank_q, rank_d;
  logic                 mark_q, mark_d;
  logic                 hit_q, hit_d;
  logic                 sel_q, sel_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [FIELD_W-1:0]   frame_q, frame_d;
  logic [RANK_BITS-1:0] rank_adj;
  logic                 first;

  // Entries ranked above the broadcast key move down one place.
  assign rank_adj = (valid_q && (rank_q > key_i)) ? rank_q - RANK_BITS'(1) : rank_q;
  assign first    = mark_q & ~below_i;

  assign below_o     = below_i | mark_q;
  assign above_o     = above_i | hit_q;
  assign valid_o     = valid_q;
  assign page_o      = page_q;
  assign frame_o     = frame_q;
  assign rank_o      = rank_adj;
  assign sel_rank_o  = sel_q ? rank_q : '0;
  assign sel_frame_o = sel_q ? frame_q : '0;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    mark_d  = mark_q;
    hit_d   = hit_q;
    sel_d   = sel_q;
    page_d  = page_q;
    frame_d = frame_q;
    case (op_i)
      CELL_MATCH_PAGE: begin
        mark_d = valid_q && (page_q == page_i);
        hit_d  = mark_d;
      end
      CELL_MATCH_FRAME: begin
        mark_d = valid_q && (frame_q == frame_i);
        hit_d  = mark_d;
      end
      CELL_MARK_FREE: begin
        mark_d = ~valid_q;
        hit_d  = 1'b0;
      end
      CELL_MARK_OLDEST: begin
        mark_d = valid_q && (rank_q == '0);
        hit_d  = 1'b0;
      end
      CELL_MARK_VALID: begin
        mark_d = valid_q;
        hit_d  = 1'b0;
      end
      CELL_PICK: begin
        sel_d = first;
      end
      CELL_TOUCH: begin
        rank_d = sel_q ? new_rank_i : rank_adj;
      end
      CELL_REPLACE: begin
        rank_d = sel_q ? new_rank_i : rank_adj;
        if (sel_q) begin
          page_d  = page_i;
          frame_d = frame_i;
        end
      end
      CELL_PLACE: begin
        if (sel_q) begin
          valid_d = 1'b1;
          page_d  = page_i;
          frame_d = frame_i;
          rank_d  = new_rank_i;
        end
      end
      CELL_DROP: begin
        if (sel_q) begin
          valid_d = 1'b0;
          rank_d  = '0;
          mark_d  = 1'b0;
        end else begin
          rank_d = rank_adj;
        end
      end
      CELL_SHIFT_FILL: begin
        // Only the top cell sees an empty neighbor when the table is full.
        if (nb_valid_i) begin
          valid_d = 1'b1;
          page_d  = nb_page_i;
          frame_d = nb_frame_i;
          rank_d  = nb_rank_i;
        end else begin
          valid_d = 1'b1;
          page_d  = page_i;
          frame_d = frame_i;
          rank_d  = new_rank_i;
        end
      end
      CELL_SHIFT_TAIL: begin
        if (!above_i) begin
          valid_d = nb_valid_i;
          page_d  = nb_page_i;
          frame_d = nb_frame_i;
          rank_d  = nb_rank_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      mark_q  <= 1'b0;
      hit_q   <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      mark_q  <= mark_d;
      hit_q   <= hit_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    frame_q <= frame_d;
  end

endmodule

// ----- src/tlb_fifo_lru_replacement_unit.sv -----
// Fully associative translation buffer with FIFO or LRU replacement.
// Input channel in_valid_i/in_ready_o carries one item: an action (lookup,
// insert, invalidate by frame), a page and a frame. Every item gives exactly
// one result item on out_valid_o/out_ready_i: found and frame_out.
// The write channel cfg_valid_i/cfg_ready_o sets the policy bit (0 FIFO,
// 1 LRU); it is always ready and is meant to be written while idle.
// The entries sit in a row of cells; commands are broadcast to the row and a
// shift moves each entry one cell down. One item is worked at a time.
// Steps for an item: match, pick and apply for lookup and insert; the unused
// action code goes from match straight to done. An invalidate repeats pick and
// apply once per removed entry, and in FIFO mode adds a compaction shift when
// it removed any. Each removal is a pick and an update of the cell row. The
// input reopens as the result becomes valid, so the block does not take a new
// item before the last one is finished.
// Reset empties the table and selects FIFO. When the receiver stalls, the
// finished result waits in the output register; the block still accepts one
// new item and holds its result back until the register is free.
module tlb_fifo_lru_replacement_unit import tlru_pkg::*; #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tlru_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tlru_rsp_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_PICK  = 6'b000100,
    S_APPLY = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  action_t              act_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [FIELD_W-1:0]   frame_q;
  logic                 policy_q;
  logic [CW-1:0]        count_q, count_d;
  logic                 any_q;
  logic                 found_q, found_d;
  logic [FIELD_W-1:0]   res_frame_q, res_frame_d;
  logic                 out_valid_q;
  tlru_rsp_t            out_data_q;

  cell_op_e             cell_op;
  logic [RW-1:0]        key;
  logic [RW-1:0]        new_rank;
  logic                 full;
  logic                 in_fire;
  logic                 out_free;

  logic [ENTRIES-1:0]   below_w;
  logic [ENTRIES-1:0]   above_w;
  logic [ENTRIES-1:0]   valid_w;
  logic [PAGE_BITS-1:0] page_w      [ENTRIES];
  logic [FIELD_W-1:0]   frame_w     [ENTRIES];
  logic [RW-1:0]        rank_w      [ENTRIES];
  logic [RW-1:0]        sel_rank_w  [ENTRIES];
  logic [FIELD_W-1:0]   sel_frame_w [ENTRIES];
  logic [RW-1:0]        sel_rank;
  logic [FIELD_W-1:0]   sel_frame;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign full        = (count_q == CW'(ENTRIES));

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic                 below_in;
    logic                 above_in;
    logic                 nb_valid;
    logic [PAGE_BITS-1:0] nb_page;
    logic [FIELD_W-1:0]   nb_frame;
    logic [RW-1:0]        nb_rank;

    if (k == 0) begin : g_first
      assign below_in = 1'b0;
    end else begin : g_inner_below
      assign below_in = below_w[k-1];
    end

    if (k == ENTRIES - 1) begin : g_last
      assign above_in = 1'b0;
      assign nb_valid = 1'b0;
      assign nb_page  = '0;
      assign nb_frame = '0;
      assign nb_rank  = '0;
    end else begin : g_inner_above
      assign above_in = above_w[k+1];
      assign nb_valid = valid_w[k+1];
      assign nb_page  = page_w[k+1];
      assign nb_frame = frame_w[k+1];
      assign nb_rank  = rank_w[k+1];
    end

    tlru_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RANK_BITS (RW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .page_i      (page_q),
      .frame_i     (frame_q),
      .key_i       (key),
      .new_rank_i  (new_rank),
      .below_i     (below_in),
      .below_o     (below_w[k]),
      .above_i     (above_in),
      .above_o     (above_w[k]),
      .nb_valid_i  (nb_valid),
      .nb_page_i   (nb_page),
      .nb_frame_i  (nb_frame),
      .nb_rank_i   (nb_rank),
      .valid_o     (valid_w[k]),
      .page_o      (page_w[k]),
      .frame_o     (frame_w[k]),
      .rank_o      (rank_w[k]),
      .sel_rank_o  (sel_rank_w[k]),
      .sel_frame_o (sel_frame_w[k])
    );
  end

  // At most one cell is selected, so an OR over the row gives its contents.
  always_comb begin
    sel_rank  = '0;
    sel_frame = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      sel_rank  = sel_rank | sel_rank_w[i];
      sel_frame = sel_frame | sel_frame_w[i];
    end
  end

  always_comb begin
    cell_op     = CELL_HOLD;
    key         = sel_rank;
    new_rank    = RW'(count_q - CW'(1));
    state_d     = state_q;
    count_d     = count_q;
    found_d     = found_q;
    res_frame_d = res_frame_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d     = S_MATCH;
          found_d     = 1'b0;
          res_frame_d = '0;
        end
      end
      S_MATCH: begin
        state_d = S_PICK;
        case (act_q)
          ACT_LOOKUP: cell_op = CELL_MATCH_PAGE;
          ACT_INSERT: begin
            if (!full) begin
              cell_op = CELL_MARK_FREE;
            end else if (policy_q) begin
              cell_op = CELL_MARK_OLDEST;
            end else begin
              cell_op = CELL_MARK_VALID;
            end
          end
          ACT_INVAL:  cell_op = CELL_MATCH_FRAME;
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PICK: begin
        cell_op = CELL_PICK;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_DONE;
        case (act_q)
          ACT_LOOKUP: begin
            if (any_q) begin
              cell_op     = CELL_TOUCH;
              found_d     = 1'b1;
              res_frame_d = sel_frame;
            end
          end
          ACT_INSERT: begin
            if (!full) begin
              cell_op  = CELL_PLACE;
              new_rank = RW'(count_q);
              count_d  = count_q + CW'(1);
            end else if (policy_q) begin
              cell_op = CELL_REPLACE;
            end else begin
              cell_op = CELL_SHIFT_FILL;
            end
          end
          ACT_INVAL: begin
            if (any_q) begin
              cell_op = CELL_DROP;
              count_d = count_q - CW'(1);
              found_d = 1'b1;
              state_d = S_PICK;
            end else if (found_q && !policy_q) begin
              state_d = S_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        // Entries above the highest removed one move down unchanged in rank.
        cell_op = CELL_SHIFT_TAIL;
        key     = '1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= 1'b0;
      count_q     <= '0;
      any_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      if (state_q == S_PICK) begin
        any_q <= below_w[ENTRIES-1];
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_frame_q <= res_frame_d;
    if (in_fire) begin
      act_q   <= in_data_i.action;
      page_q  <= PAGE_BITS'(in_data_i.page);
      frame_q <= in_data_i.frame;
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q.found     <= found_q;
      out_data_q.frame_out <= res_frame_q;
    end
  end

endmodule

// ----- src/tlru_checker.sv -----
module tlru_checker import tlru_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input tlru_req_t in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input tlru_rsp_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o,
  input logic      cfg_data_i
);

  // A result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item dropped or changed while stalled");

  // An accepted item keeps the input closed through the match state and the state after it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened too early after an item");

  // A new result appears exactly when the block returns to taking items.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result appeared while an item was still in work");

  // A nonzero frame is only reported with a hit.
  a_frame_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_out != '0) |-> out_data_o.found)
    else $error("frame reported without a hit");

endmodule

bind tlb_fifo_lru_replacement_unit tlru_checker u_tlru_checker (.*);

// ----- verif/tb.sv -----
module tb;
  import tlru_pkg::*;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned RANK_W    = $clog2(ENTRIES);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REQS = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [FIELD_W-1:0] PAGE_MASK = FIELD_W'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [FIELD_W-1:0] ALL_ONES  = '1;

  // The one action code that the block leaves unused.
  localparam action_t ACT_UNUSED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  tlru_req_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  tlru_rsp_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  tlb_fifo_lru_replacement_unit #(
    .ENTRIES  (ENTRIES),
    .PAGE_BITS(PAGE_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the translation table.
  bit                 tbl_valid [ENTRIES];
  logic [FIELD_W-1:0] tbl_page  [ENTRIES];
  logic [FIELD_W-1:0] tbl_frame [ENTRIES];
  logic [RANK_W-1:0]  tbl_rank  [ENTRIES];
  bit                 policy_lru;

  tlru_req_t   pending_reqs[$];
  tlru_rsp_t   expected_rsps[$];
  tlru_rsp_t   want;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned feed_gap;
  int unsigned drain_hold;
  bit          calm;
  bit          show;
  bit          accept_now;
  bit          req_taken;
  bit          rsp_taken;
  bit          cfg_taken;

  function automatic int unsigned count_live();
    int unsigned n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  // Take entry i out of the recency order; the ranks above it close the gap.
  function automatic void drop_entry(int unsigned i);
    if (!tbl_valid[i]) return;
    for (int j = 0; j < ENTRIES; j++) begin
      if (j != i && tbl_valid[j] && tbl_rank[j] > tbl_rank[i]) tbl_rank[j] = tbl_rank[j] - 1'b1;
    end
    tbl_valid[i] = 1'b0;
    tbl_rank[i]  = '0;
  endfunction

  function automatic void place_entry(int unsigned i, logic [FIELD_W-1:0] pg,
                                      logic [FIELD_W-1:0] fr);
    int unsigned n;
    n = count_live();
    tbl_valid[i] = 1'b1;
    tbl_page[i]  = pg;
    tbl_frame[i] = fr;
    tbl_rank[i]  = RANK_W'(n);
  endfunction

  function automatic void shift_down(int unsigned from);
    for (int i = from; i + 1 < ENTRIES; i++) begin
      tbl_valid[i] = tbl_valid[i+1];
      tbl_page[i]  = tbl_page[i+1];
      tbl_frame[i] = tbl_frame[i+1];
      tbl_rank[i]  = tbl_rank[i+1];
    end
    tbl_valid[ENTRIES-1] = 1'b0;
    tbl_page[ENTRIES-1]  = '0;
    tbl_frame[ENTRIES-1] = '0;
    tbl_rank[ENTRIES-1]  = '0;
  endfunction

  function automatic tlru_rsp_t translate(tlru_req_t req);
    tlru_rsp_t          rsp;
    logic [FIELD_W-1:0] pg;
    int unsigned        slot;
    int unsigned        victim;
    int unsigned        last;
    int unsigned        top;
    bit                 hit;
    rsp  = '0;
    pg   = req.page & PAGE_MASK;
    hit  = 1'b0;
    case (req.action)
      ACT_LOOKUP: begin
        for (int i = 0; i < ENTRIES && !hit; i++) begin
          if (tbl_valid[i] && tbl_page[i] == pg) begin
            hit = 1'b1;
            rsp.found = 1'b1;
            rsp.frame_out = tbl_frame[i];
            top = count_live() - 1;
            for (int j = 0; j < ENTRIES; j++) begin
              if (j != i && tbl_valid[j] && tbl_rank[j] > tbl_rank[i])
                tbl_rank[j] = tbl_rank[j] - 1'b1;
            end
            tbl_rank[i] = RANK_W'(top);
          end
        end
      end
      ACT_INSERT: begin
        slot = ENTRIES;
        for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < ENTRIES) begin
          place_entry(slot, pg, req.frame);
        end else if (!policy_lru) begin
          drop_entry(0);
          shift_down(0);
          place_entry(ENTRIES - 1, pg, req.frame);
        end else begin
          victim = 0;
          for (int i = 1; i < ENTRIES; i++) if (tbl_rank[i] < tbl_rank[victim]) victim = i;
          drop_entry(victim);
          place_entry(victim, pg, req.frame);
        end
      end
      ACT_INVAL: begin
        last = ENTRIES;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_frame[i] == req.frame) begin
            drop_entry(i);
            tbl_page[i]  = '0;
            tbl_frame[i] = '0;
            last = i;
            rsp.found = 1'b1;
          end
        end
        // FIFO compaction covers only the slots after the last removed entry.
        if (!policy_lru && last < ENTRIES - 1) shift_down(last);
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic queue_req(action_t act, logic [FIELD_W-1:0] pg, logic [FIELD_W-1:0] fr);
    tlru_req_t req;
    req.action = act;
    req.page   = pg;
    req.frame  = fr;
    pending_reqs.push_back(req);
  endtask

  // Every item gives a result, so an empty store means the block is idle.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_policy(bit lru);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lru;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver: the head of the queue is dropped only once it has been taken.
  always @(negedge clk_i) begin
    if (req_taken) begin
      req_taken = 1'b0;
      void'(pending_reqs.pop_front());
      feed_gap = calm ? 0 : $urandom_range(0, 3);
      show = 1'b0;
    end else begin
      show = in_valid_i;
    end
    if (!show && rst_ni && pending_reqs.size() != 0) begin
      if (feed_gap > 0) feed_gap--;
      else show = 1'b1;
    end
    in_valid_i <= show;
    if (show) in_data_i <= pending_reqs[0];
  end

  // Result sink: after each taken item, hold off for a random stretch that runs down only while a result waits.
  always @(negedge clk_i) begin
    if (rsp_taken) begin
      rsp_taken = 1'b0;
      drain_hold = calm ? 0 : $urandom_range(0, 3);
    end
    if (drain_hold > 0) begin
      if (out_valid_o) drain_hold--;
      accept_now = 1'b0;
    end else begin
      accept_now = rst_ni;
    end
    out_ready_i <= accept_now;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rsp_taken = 1'b1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with nothing expected: found=%0b frame_out=%h",
                   $time, out_data_o.found, out_data_o.frame_out);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b actual %0b",
                     $time, want.found, out_data_o.found);
            mismatches++;
          end
          if (out_data_o.frame_out !== want.frame_out) begin
            $display("%0t: frame_out mismatch: expected %h actual %h",
                     $time, want.frame_out, out_data_o.frame_out);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        req_taken = 1'b1;
        expected_rsps.push_back(translate(in_data_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_taken = 1'b1;
        policy_lru = cfg_data_i;
      end
    end
  end

  // Cycle limit, and random switching between stretches with random gaps and gap-free stretches.
  always @(posedge clk_i) begin
    cycles++;
    if ($urandom_range(0, 99) == 0) calm = !calm;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [FIELD_W-1:0] page_pool [24];
    logic [FIELD_W-1:0] frame_pool[16];
    logic [FIELD_W-1:0] pg;
    logic [FIELD_W-1:0] fr;
    action_t            act;
    int unsigned        pick;

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_page[i]  = '0;
      tbl_frame[i] = '0;
      tbl_rank[i]  = '0;
    end
    policy_lru = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_policy(1'b0);
    // Misses on an empty table, then extremes and a duplicate page.
    queue_req(ACT_LOOKUP, '0, '0);
    queue_req(ACT_INVAL, '0, '0);
    queue_req(ACT_INSERT, '0, ALL_ONES);
    queue_req(ACT_INSERT, ALL_ONES, '0);
    queue_req(ACT_INSERT, '0, FIELD_W'(1));
    queue_req(ACT_LOOKUP, '0, '0);
    queue_req(ACT_LOOKUP, ALL_ONES, ALL_ONES);
    queue_req(ACT_UNUSED, ALL_ONES, ALL_ONES);
    queue_req(ACT_INVAL, ALL_ONES, ALL_ONES);
    // Fill the table, evict in FIFO order, then remove several entries at once.
    for (int i = 0; i < 14; i++) queue_req(ACT_INSERT, FIELD_W'(20'h100 + i), FIELD_W'(i % 4));
    queue_req(ACT_INSERT, FIELD_W'(20'hABCDE), FIELD_W'(5));
    queue_req(ACT_INVAL, '0, FIELD_W'(2));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_policy(ph % 2 == 0);
      for (int i = 0; i < 24; i++) page_pool[i] = FIELD_W'($urandom);
      for (int i = 0; i < 16; i++) frame_pool[i] = FIELD_W'($urandom);
      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 44) act = ACT_LOOKUP;
        else if (pick < 84) act = ACT_INSERT;
        else if (pick < 96) act = ACT_INVAL;
        else act = ACT_UNUSED;
        pg = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom) : page_pool[$urandom_range(0, 23)];
        fr = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom) : frame_pool[$urandom_range(0, 15)];
        queue_req(act, pg, fr);
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
